// ===== hdl/prsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer rotate and scroll accumulate: shared package
// Item types, register indexes, angle and divider tables and their lookups.
// ----------------------------------------------------------------------------
package prsa_pkg;

  localparam int ANGLE_COUNT   = 11;
  localparam int DIVIDER_COUNT = 6;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int ANGLE_W     = 4;
  localparam int DIV_W       = 3;
  localparam int SHIFT_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION_INDEX = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER_INDEX  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_INVERT  = 2'd2;

  localparam logic [ANGLE_W-1:0] ROTATION_RESET = 4'd3;
  localparam logic [DIV_W-1:0]   DIVIDER_RESET  = 3'd4;
  localparam logic               INVERT_RESET   = 1'b1;

  // Sine and cosine in Q2.14 for -75 to 75 degrees in 15 degree steps.
  localparam logic signed [15:0] SIN_Q14 [ANGLE_COUNT] = '{
    -16'sd15826, -16'sd14189, -16'sd11585, -16'sd8192, -16'sd4240, 16'sd0,
    16'sd4240, 16'sd8192, 16'sd11585, 16'sd14189, 16'sd15826
  };
  localparam logic signed [15:0] COS_Q14 [ANGLE_COUNT] = '{
    16'sd4240, 16'sd8192, 16'sd11585, 16'sd14189, 16'sd15826, 16'sd16384,
    16'sd15826, 16'sd14189, 16'sd11585, 16'sd8192, 16'sd4240
  };
  localparam logic [SHIFT_W-1:0] SHIFT_TAB [DIVIDER_COUNT] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
  };

  typedef struct packed {
    logic              mode;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic signed [7:0] wheel_h;
    logic signed [7:0] wheel_v;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] out_x;
    logic signed [7:0] out_y;
    logic signed [7:0] out_h;
    logic signed [7:0] out_v;
  } out_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] rotation_index;
    logic [DIV_W-1:0]   divider_index;
    logic               scroll_invert;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic signed [7:0] xr;
    logic signed [7:0] yr;
    logic signed [7:0] wheel_h;
    logic signed [7:0] wheel_v;
  } rot_item_t;

  function automatic logic [ANGLE_W-1:0] angle_index(input logic [ANGLE_W-1:0] idx);
    return (int'(idx) < ANGLE_COUNT) ? idx : ANGLE_W'(ANGLE_COUNT - 1);
  endfunction

  function automatic logic [SHIFT_W-1:0] divider_shift(input logic [DIV_W-1:0] idx);
    logic [DIV_W-1:0] sel;
    sel = (int'(idx) < DIVIDER_COUNT) ? idx : DIV_W'(DIVIDER_COUNT - 1);
    return SHIFT_TAB[sel];
  endfunction

endpackage

// ===== hdl/prsa_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer rotate and scroll accumulate: configuration registers
// Decodes the write port into the angle, divider and invert registers.
// ----------------------------------------------------------------------------
module prsa_cfg import prsa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROTATION_INDEX: cfg_d.rotation_index = cfg_data_i[ANGLE_W-1:0];
        REG_DIVIDER_INDEX:  cfg_d.divider_index  = cfg_data_i[DIV_W-1:0];
        REG_SCROLL_INVERT:  cfg_d.scroll_invert  = cfg_data_i[0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation_index <= ROTATION_RESET;
      cfg_q.divider_index  <= DIVIDER_RESET;
      cfg_q.scroll_invert  <= INVERT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/prsa_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer rotate and scroll accumulate: rotation stage
// Rotates the motion vector by the table angle and registers the result.
// ----------------------------------------------------------------------------
module prsa_rotate import prsa_pkg::*; (
  input  logic               clk_i,
  input  logic [ANGLE_W-1:0] rotation_index_i,
  input  logic               load_i,
  input  in_item_t           item_i,
  output rot_item_t          rot_o
);

  logic [ANGLE_W-1:0]  idx;
  logic signed [15:0]  cos_v, sin_v;
  logic signed [23:0]  xc, ys, yc, xs;
  logic signed [24:0]  sum_x, sum_y;
  rot_item_t           rot_d, rot_q;

  function automatic logic signed [7:0] trunc_sat(input logic signed [24:0] v);
    logic [24:0] mag;
    logic [10:0] q;
    logic [7:0]  r;
    mag = v[24] ? 25'(-v) : 25'(v);
    q   = mag[24:14];
    if (!v[24]) begin
      r = (q > 11'd127) ? 8'd127 : q[7:0];
    end else begin
      r = (q > 11'd128) ? 8'h80 : 8'(~q[7:0] + 8'd1);
    end
    return r;
  endfunction

  always_comb begin
    idx   = angle_index(rotation_index_i);
    cos_v = COS_Q14[idx];
    sin_v = SIN_Q14[idx];
    xc    = item_i.delta_x * cos_v;
    ys    = item_i.delta_y * sin_v;
    yc    = item_i.delta_y * cos_v;
    xs    = item_i.delta_x * sin_v;
    sum_x = 25'(xc) + 25'(ys);
    sum_y = 25'(yc) - 25'(xs);
    rot_d.mode    = item_i.mode;
    rot_d.xr      = trunc_sat(sum_x);
    rot_d.yr      = trunc_sat(sum_y);
    rot_d.wheel_h = item_i.wheel_h;
    rot_d.wheel_v = item_i.wheel_v;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== hdl/prsa_scroll.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer rotate and scroll accumulate: scroll stage
// Cursor output or dominant-axis scroll accumulation with wheel clamping.
// ----------------------------------------------------------------------------
module prsa_scroll import prsa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DIV_W-1:0] divider_index_i,
  input  logic             scroll_invert_i,
  input  logic             load_i,
  input  rot_item_t        rot_i,
  output out_item_t        item_o
);

  typedef struct packed {
    logic [15:0]       acc;
    logic signed [7:0] wheel;
    logic              step;
  } axis_t;

  logic [15:0]        acc_h_q, acc_h_d, acc_v_q, acc_v_d;
  logic [SHIFT_W-1:0] shift;
  logic [8:0]         abs_x, abs_y;
  logic               x_dom;
  logic [15:0]        xr16, yr16, dh, dv;
  axis_t              ax_h, ax_v;
  out_item_t          out_d, out_q;

  function automatic axis_t apply_axis(input logic [15:0] acc, input logic signed [7:0] wheel,
                                       input logic [SHIFT_W-1:0] sh);
    logic signed [15:0] q;
    logic signed [16:0] wsum, qc;
    axis_t              r;
    q      = $signed(acc) >>> sh;
    wsum   = 17'(wheel) + 17'(q);
    r.acc  = acc;
    r.wheel = wheel;
    r.step = (q != 16'sd0);
    if (r.step) begin
      if (wsum > 17'sd127) begin
        qc = 17'sd127 - 17'(wheel);
      end else if (wsum < -17'sd127) begin
        qc = -17'sd127 - 17'(wheel);
      end else begin
        qc = 17'(q);
      end
      r.wheel = 8'(17'(wheel) + qc);
      r.acc   = acc - (qc[15:0] << sh);
    end
    return r;
  endfunction

  always_comb begin
    shift = divider_shift(divider_index_i);
    abs_x = rot_i.xr[7] ? 9'(9'd0 - {rot_i.xr[7], rot_i.xr}) : {1'b0, rot_i.xr};
    abs_y = rot_i.yr[7] ? 9'(9'd0 - {rot_i.yr[7], rot_i.yr}) : {1'b0, rot_i.yr};
    x_dom = abs_x > abs_y;
    xr16  = {{8{rot_i.xr[7]}}, rot_i.xr};
    yr16  = {{8{rot_i.yr[7]}}, rot_i.yr};
    dh    = 16'd0;
    dv    = 16'd0;
    if (x_dom) begin
      dh = scroll_invert_i ? xr16 : 16'(16'd0 - xr16);
    end else begin
      dv = scroll_invert_i ? 16'(16'd0 - yr16) : yr16;
    end
    ax_h = apply_axis(16'(acc_h_q + dh), rot_i.wheel_h, shift);
    ax_v = apply_axis(16'(acc_v_q + dv), rot_i.wheel_v, shift);

    acc_h_d = acc_h_q;
    acc_v_d = acc_v_q;
    if (rot_i.mode) begin
      out_d.out_x = 8'sd0;
      out_d.out_y = 8'sd0;
      out_d.out_h = ax_h.wheel;
      out_d.out_v = ax_v.wheel;
      if (load_i) begin
        acc_h_d = ax_h.acc;
        acc_v_d = ax_v.acc;
      end
    end else begin
      out_d.out_x = (rot_i.xr == 8'sh80) ? 8'sd127 : 8'(-rot_i.xr);
      out_d.out_y = rot_i.yr;
      out_d.out_h = rot_i.wheel_h;
      out_d.out_v = rot_i.wheel_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_h_q <= 16'd0;
      acc_v_q <= 16'd0;
    end else begin
      acc_h_q <= acc_h_d;
      acc_v_q <= acc_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q <= out_d;
    end
  end

  assign item_o = out_q;

  a_cursor_keeps_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && !rot_i.mode) |=> ($stable(acc_h_q) && $stable(acc_v_q)))
    else $error("accumulators changed on a cursor item");

  a_scroll_zero_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && rot_i.mode) |=> (out_q.out_x == 8'sd0 && out_q.out_y == 8'sd0))
    else $error("scroll item produced cursor motion");

  a_wheel_h_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && rot_i.mode && ax_h.step) |=> (out_q.out_h != 8'sh80))
    else $error("horizontal wheel left the clamp range");

  a_wheel_v_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && rot_i.mode && ax_v.step) |=> (out_q.out_v != 8'sh80))
    else $error("vertical wheel left the clamp range");

endmodule

// ===== hdl/pointer_rotate_scroll_accumulate_top.sv =====
`timescale 1ns / 1ps
// An accepted item moves from the input register through the rotation register into the result register.
// Throughput: one item per cycle; the three registers (input, rotation, result)
// advance whenever the stage after them is empty or being emptied.
// The scroll accumulators are updated as a scroll item enters the result register.
// Reset clears the valid bits and the accumulators and loads the register defaults.
// ----------------------------------------------------------------------------
// Pointer rotate and scroll accumulate: top level
// Rotates trackball motion and turns it into cursor motion or wheel scrolling.
// ----------------------------------------------------------------------------
module pointer_rotate_scroll_accumulate_top import prsa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_item_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  rot_item_t rot;
  logic      in_vld_q, in_vld_d, rot_vld_q, rot_vld_d, out_vld_q, out_vld_d;
  logic      adv_in, adv_rot, adv_out;

  prsa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign adv_out = !out_vld_q || out_ready_i;
  assign adv_rot = !rot_vld_q || adv_out;
  assign adv_in  = !in_vld_q || adv_rot;

  always_comb begin
    in_vld_d  = adv_in  ? in_valid_i : in_vld_q;
    rot_vld_d = adv_rot ? in_vld_q   : rot_vld_q;
    out_vld_d = adv_out ? rot_vld_q  : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      rot_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      rot_vld_q <= rot_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && adv_in) begin
      in_q <= in_item_i;
    end
  end

  prsa_rotate u_rotate (
    .clk_i            (clk_i),
    .rotation_index_i (cfg.rotation_index),
    .load_i           (in_vld_q && adv_rot),
    .item_i           (in_q),
    .rot_o            (rot)
  );

  prsa_scroll u_scroll (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .divider_index_i (cfg.divider_index),
    .scroll_invert_i (cfg.scroll_invert),
    .load_i          (rot_vld_q && adv_out),
    .rot_i           (rot),
    .item_o          (out_item_o)
  );

  assign in_ready_o  = adv_in;
  assign out_valid_o = out_vld_q;

endmodule

// ===== tb/sv/pointer_rotate_scroll_accumulate_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer rotate and scroll accumulate: self-checking testbench
// Drives directed and random motion items through the block under several
// register settings. A scoreboard predicts each result, with its own copy of
// the scroll accumulators, and checks every result in order.
// ----------------------------------------------------------------------------
module pointer_rotate_scroll_accumulate_top_test;
  import prsa_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int ANGLES   = 11;
  localparam int DIVIDERS = 6;
  localparam int SIN_TAB [ANGLES] = '{
    -15826, -14189, -11585, -8192, -4240, 0, 4240, 8192, 11585, 14189, 15826
  };
  localparam int COS_TAB [ANGLES] = '{
    4240, 8192, 11585, 14189, 15826, 16384, 15826, 14189, 11585, 8192, 4240
  };

  class motion_scoreboard;
    logic [3:0]         rot_sel;
    logic [2:0]         div_sel;
    logic               invert;
    logic signed [15:0] acc [2];
    out_item_t          expected_reports [$];
    int                 errors;

    function new();
      rot_sel = 4'd3;
      div_sel = 3'd4;
      invert  = 1'b1;
      acc[0]  = '0;
      acc[1]  = '0;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROTATION_INDEX: rot_sel = data;
        REG_DIVIDER_INDEX:  div_sel = data[2:0];
        REG_SCROLL_INVERT:  invert  = data[0];
        default: ;
      endcase
    endfunction

    function int sat_byte(int v);
      return (v > 127) ? 127 : ((v < -128) ? -128 : v);
    endfunction

    function int rotate_trunc(int v);
      int m;
      m = (v < 0) ? -v : v;
      m = m >>> 14;
      return (v < 0) ? -m : m;
    endfunction

    // Moves whole scroll steps from one accumulator into the wheel amount.
    function int drain_axis(int axis, int wheel, int sh);
      int q;
      q = int'(acc[axis]) >>> sh;
      if (q != 0) begin
        if (wheel + q > 127) q = 127 - wheel;
        else if (wheel + q < -127) q = -127 - wheel;
        wheel += q;
        acc[axis] = 16'(int'(acc[axis]) - q * (1 << sh));
      end
      return wheel;
    endfunction

    function void add_report(in_item_t it);
      int x, y, h, v, ai, sh, xr, yr, dh, dv;
      out_item_t e;
      x  = int'(it.delta_x);
      y  = int'(it.delta_y);
      h  = int'(it.wheel_h);
      v  = int'(it.wheel_v);
      ai = (rot_sel < ANGLES) ? int'(rot_sel) : ANGLES - 1;
      sh = ((div_sel < DIVIDERS) ? int'(div_sel) : DIVIDERS - 1) + 1;
      xr = sat_byte(rotate_trunc(x * COS_TAB[ai] + y * SIN_TAB[ai]));
      yr = sat_byte(rotate_trunc(y * COS_TAB[ai] - x * SIN_TAB[ai]));
      if (it.mode) begin
        if (((xr < 0) ? -xr : xr) > ((yr < 0) ? -yr : yr)) yr = 0;
        else xr = 0;
        dh = invert ? xr : -xr;
        dv = invert ? -yr : yr;
        acc[0] = 16'(int'(acc[0]) + dh);
        acc[1] = 16'(int'(acc[1]) + dv);
        h = drain_axis(0, h, sh);
        v = drain_axis(1, v, sh);
        e.out_x = '0;
        e.out_y = '0;
      end else begin
        e.out_x = 8'(sat_byte(-xr));
        e.out_y = 8'(yr);
      end
      e.out_h = 8'(h);
      e.out_v = 8'(v);
      expected_reports.push_back(e);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_report(out_item_t got);
      string names [4];
      out_item_t e;
      names = '{"out_x", "out_y", "out_h", "out_v"};
      if (expected_reports.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
      end else begin
        e = expected_reports.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[31-8*i -: 8] !== e[31-8*i -: 8])
            report($sformatf("%s got %0d expected %0d", names[i],
                             $signed(got[31-8*i -: 8]), $signed(e[31-8*i -: 8])));
        end
      end
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  in_item_t               in_item_i;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  out_item_t              out_item_o;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  motion_scoreboard board = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  pointer_rotate_scroll_accumulate_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The receiver changes between steady, light, heavy and sparse stalling.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_report(out_item_o);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ($urandom_range(0, 11) != 0);
    endcase
  end

  function automatic in_item_t make_item(bit m, int x, int y, int h, int v);
    in_item_t it;
    it.mode    = m;
    it.delta_x = 8'(x);
    it.delta_y = 8'(y);
    it.wheel_h = 8'(h);
    it.wheel_v = 8'(v);
    return it;
  endfunction

  function automatic int extreme_wheel();
    int pick;
    pick = $urandom_range(0, 4);
    case (pick)
      0: return 127;
      1: return -127;
      2: return -128;
      default: return int'($urandom_range(0, 255)) - 128;
    endcase
  endfunction

  function automatic in_item_t random_item();
    int pick;
    in_item_t it;
    pick = $urandom_range(0, 99);
    it.delta_x = 8'($urandom);
    it.delta_y = 8'($urandom);
    if (pick % 3 == 0) begin
      it.delta_x = 8'(int'($urandom_range(0, 16)) - 8);
      it.delta_y = 8'(int'($urandom_range(0, 16)) - 8);
    end
    it.wheel_h = 8'($urandom);
    it.wheel_v = 8'($urandom);
    if (pick < 50) begin
      it.mode = 1'b1;
      if ($urandom_range(0, 4) != 0) begin
        it.wheel_h = '0;
        it.wheel_v = '0;
      end
    end else if (pick < 80) begin
      it.mode = 1'b0;
    end else begin
      it.mode    = 1'b1;
      it.wheel_h = 8'(extreme_wheel());
      it.wheel_v = 8'(extreme_wheel());
    end
    return it;
  endfunction

  // Items go out in bursts; valid only drops between bursts.
  task send_item(in_item_t it);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.add_report(it);
    burst_left--;
  endtask

  // A steady push along one direction with the wheel held at a limit, so
  // that an accumulator grows far past one report's worth and wraps.
  task run_streak(int n, bit x_neg, int wheel);
    int mag;
    for (int i = 0; i < n; i++) begin
      mag = $urandom_range(100, 127);
      send_item(make_item(1'b1, x_neg ? -mag : mag, int'($urandom_range(0, 60)) - 30,
                          wheel, wheel));
    end
  endtask

  task drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  task directed_items();
    send_item(make_item(1'b0, 0, 0, 0, 0));
    send_item(make_item(1'b0, 127, 127, 127, 127));
    send_item(make_item(1'b0, -128, -128, -127, -127));
    send_item(make_item(1'b0, 127, -128, -128, -128));
    send_item(make_item(1'b0, -128, 127, 0, 0));
    send_item(make_item(1'b0, 100, 27, 5, -5));
    send_item(make_item(1'b0, 1, -1, 1, -1));
    send_item(make_item(1'b1, 0, 0, -128, -128));
    send_item(make_item(1'b1, 127, 127, 0, 0));
    send_item(make_item(1'b1, -128, -128, 0, 0));
    send_item(make_item(1'b1, 127, -128, 0, 0));
    send_item(make_item(1'b1, -128, 127, 0, 0));
    send_item(make_item(1'b1, 100, 27, 0, 0));
    repeat (3) send_item(make_item(1'b1, 127, -128, 127, 127));
    repeat (3) send_item(make_item(1'b1, -128, 127, -127, -127));
    send_item(make_item(1'b1, 0, 0, -128, -128));
    send_item(make_item(1'b1, 1, 0, 127, -127));
  endtask

  initial begin
    logic [3:0] rot_set [6];
    logic [2:0] div_set [6];
    logic       inv_set [6];
    logic [3:0] rot;
    logic [2:0] div;
    logic       inv;
    rot_set = '{4'd0, 4'd10, 4'd15, 4'd5, 4'd11, 4'd7};
    div_set = '{3'd0, 3'd5, 3'd7, 3'd6, 3'd1, 3'd3};
    inv_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    for (int p = 0; p < 10; p++) begin
      drain();
      if (p < 6) begin
        rot = rot_set[p];
        div = div_set[p];
        inv = inv_set[p];
      end else begin
        rot = 4'($urandom_range(0, 15));
        div = 3'($urandom_range(0, 7));
        inv = 1'($urandom_range(0, 1));
      end
      write_reg(REG_ROTATION_INDEX, rot);
      write_reg(REG_DIVIDER_INDEX, {1'($urandom), div});
      write_reg(REG_SCROLL_INVERT, {3'($urandom), inv});
      write_reg(REG_UNUSED, 4'($urandom));
      cfg_we_i <= 1'b0;
      if (p == 1) run_streak(300, 1'b1, -128);
      if (p == 3) run_streak(300, 1'b0, 127);
      repeat (100) send_item(random_item());
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
